// ----- rtl/core/pdss_pkg.sv -----
// ----------------------------------------------------------------------------
// pdss_pkg
// Types, constants and helper functions for the PLL divider search unit.
// ----------------------------------------------------------------------------
package pdss_pkg;

   localparam int PARENT_W = 27;
   localparam int RATE_W   = 32;
   localparam int FRATE_W  = 38;  // full-width rate before saturation
   localparam int DIVD_W   = 62;  // divider dividend / quotient width
   localparam int DIVS_W   = 27;  // divider divisor width
   localparam int MUL_A_W  = 32;
   localparam int MUL_B_W  = 27;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int FRAC_BITS = 16;

   localparam logic [5:0] PDIV_LIMIT = 6'd63;
   localparam logic [2:0] SDIV_LIMIT = 3'd6;

   localparam logic [PARENT_W-1:0] PARENT_RESET = 27'd24000000;
   localparam logic [9:0] M_MIN = 10'd64;
   localparam logic [9:0] M_MAX = 10'd1023;
   localparam logic signed [15:0] K_MAX = 16'sh7FFF;
   localparam logic signed [15:0] K_MIN = 16'sh8000;

   localparam logic [1:0] KIND_INT = 2'd0;

   localparam logic [1:0] PATH_TABLE  = 2'd0;
   localparam logic [1:0] PATH_KADJ   = 2'd1;
   localparam logic [1:0] PATH_SEARCH = 2'd2;

   typedef struct packed {
      logic [1:0]        pll_kind;
      logic [RATE_W-1:0] target_rate;
      logic [9:0]        cur_mdiv;
      logic [5:0]        cur_pdiv;
      logic [2:0]        cur_sdiv;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]  out_rate;
      logic [9:0]         out_mdiv;
      logic [5:0]         out_pdiv;
      logic [2:0]         out_sdiv;
      logic signed [15:0] out_kdiv;
      logic [1:0]         path_taken;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic [RATE_W-1:0]  rate;
      logic [9:0]         m;
      logic [5:0]         p;
      logic [2:0]         s;
      logic signed [15:0] k;
   } tab_entry_type;

   typedef struct packed {
      logic          hit;
      tab_entry_type entry;
   } tab_hit_type;

   localparam tab_entry_type INT_TAB [14] = '{
      '{32'd1800000000, 10'd225, 6'd3, 3'd0, 16'sd0},
      '{32'd1600000000, 10'd200, 6'd3, 3'd0, 16'sd0},
      '{32'd1500000000, 10'd375, 6'd3, 3'd1, 16'sd0},
      '{32'd1400000000, 10'd350, 6'd3, 3'd1, 16'sd0},
      '{32'd1200000000, 10'd300, 6'd3, 3'd1, 16'sd0},
      '{32'd1000000000, 10'd250, 6'd3, 3'd1, 16'sd0},
      '{32'd800000000,  10'd200, 6'd3, 3'd1, 16'sd0},
      '{32'd750000000,  10'd250, 6'd2, 3'd2, 16'sd0},
      '{32'd700000000,  10'd350, 6'd3, 3'd2, 16'sd0},
      '{32'd640000000,  10'd320, 6'd3, 3'd2, 16'sd0},
      '{32'd600000000,  10'd300, 6'd3, 3'd2, 16'sd0},
      '{32'd416000000,  10'd208, 6'd3, 3'd2, 16'sd0},
      '{32'd320000000,  10'd160, 6'd3, 3'd2, 16'sd0},
      '{32'd208000000,  10'd208, 6'd3, 3'd3, 16'sd0}
   };

   localparam tab_entry_type FRAC_TAB [4] = '{
      '{32'd1039500000, 10'd173, 6'd2, 3'd1, 16'sd16384},
      '{32'd650000000,  10'd325, 6'd3, 3'd2, 16'sd0},
      '{32'd594000000,  10'd198, 6'd2, 3'd2, 16'sd0},
      '{32'd519750000,  10'd173, 6'd2, 3'd2, 16'sd16384}
   };

   function automatic tab_hit_type tab_lookup(input logic [1:0] kind,
                                              input logic [RATE_W-1:0] target);
      tab_hit_type r;
      r = '0;
      if (kind == KIND_INT) begin
         for (int i = 0; i < 14; i++) begin
            if (!r.hit && target == INT_TAB[i].rate) begin
               r.hit   = 1'b1;
               r.entry = INT_TAB[i];
            end
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (!r.hit && target == FRAC_TAB[i].rate) begin
               r.hit   = 1'b1;
               r.entry = FRAC_TAB[i];
            end
         end
      end
      return r;
   endfunction

   // k = q - m*65536, saturated to 16 bits
   function automatic logic signed [15:0] k_sat(input logic [DIVD_W-1:0] q,
                                                input logic [9:0] m);
      logic [DIVD_W-1:0] base;
      logic [DIVD_W-1:0] d;
      logic signed [15:0] k;
      base = DIVD_W'({m, 16'b0});
      if (q >= base) begin
         d = q - base;
         k = (d > DIVD_W'(32767)) ? K_MAX : 16'(d);
      end else begin
         d = base - q;
         k = (d > DIVD_W'(32768)) ? K_MIN : 16'(~d + DIVD_W'(1));
      end
      return k;
   endfunction

   function automatic logic [9:0] clamp_m(input logic [DIVD_W-1:0] q);
      logic [9:0] m;
      if (q < DIVD_W'(M_MIN))
         m = M_MIN;
      else if (q > DIVD_W'(M_MAX))
         m = M_MAX;
      else
         m = q[9:0];
      return m;
   endfunction

endpackage

// ----- rtl/core/pdss_div.sv -----
// ----------------------------------------------------------------------------
// pdss_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdss_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pdss_pkg::div_req_type div_req,
   output pdss_pkg::div_rsp_type div_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic [pdss_pkg::DIVS_W:0]     rem_ff, rem_in;
   logic [pdss_pkg::DIVD_W-1:0]   quo_ff, quo_in;
   logic [pdss_pkg::DIVS_W-1:0]   dvs_ff, dvs_in;
   logic [pdss_pkg::DIVS_W:0]     rem_sh;

   assign rem_sh = {rem_ff[pdss_pkg::DIVS_W-1:0], quo_ff[pdss_pkg::DIVD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[pdss_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[pdss_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(pdss_pkg::DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- rtl/core/pdss_mul.sv -----
// ----------------------------------------------------------------------------
// pdss_mul
// Shared 32x27 multiplier with registered, enable-held product.
// ----------------------------------------------------------------------------
module pdss_mul (
   input  logic                        clock,
   input  pdss_pkg::mul_req_type       mul_req,
   output logic [pdss_pkg::PROD_W-1:0] prod
);

   logic [pdss_pkg::PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_req.en)
         prod_in = pdss_pkg::PROD_W'(mul_req.a) * pdss_pkg::PROD_W'(mul_req.b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/pll_divider_settings_search_unit.sv -----
// ----------------------------------------------------------------------------
// Paths: table hit, k-only adjustment, or a search over p and s candidates.
// Throughput: one request at a time; req_stall is high until the response leaves.
// Each search candidate uses the shared 62-step divider three times.
// Reset: synchronous, active high; returns to idle, parent rate register to 24000000.
// ----------------------------------------------------------------------------
// pll_divider_settings_search_unit
// Picks m, p, s, k dividers of a fractional PLL for a wanted rate.
// ----------------------------------------------------------------------------
module pll_divider_settings_search_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pdss_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pdss_pkg::rsp_type               rsp_data,
   input  logic                            csr_write,
   input  logic [pdss_pkg::PARENT_W-1:0]   csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_TAB  = 8'b0000_0010,
      ST_RMUL = 8'b0000_0100,
      ST_RDIV = 8'b0000_1000,
      ST_QMUL = 8'b0001_0000,
      ST_MDIV = 8'b0010_0000,
      ST_QDIV = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      PH_LO   = 4'b0001,
      PH_HI   = 4'b0010,
      PH_KFIN = 4'b0100,
      PH_SRCH = 4'b1000
   } phase_type;

   state_type                          state_ff, state_in;
   phase_type                          ph_ff, ph_in;
   pdss_pkg::req_type                  req_ff, req_in;
   pdss_pkg::rsp_type                  rsp_ff, rsp_in;
   logic [pdss_pkg::PARENT_W-1:0]      parent_ff, parent_in;
   logic [9:0]                         m_ff, m_in;
   logic [5:0]                         p_ff, p_in;
   logic [2:0]                         s_ff, s_in;
   logic signed [15:0]                 k_ff, k_in;
   logic [pdss_pkg::FRATE_W-1:0]       lo_ff, lo_in;
   logic [pdss_pkg::FRATE_W-1:0]       best_ff, best_in;
   logic                               have_ff, have_in;
   logic                               div_run_ff, div_run_in;

   pdss_pkg::div_req_type              div_req;
   pdss_pkg::div_rsp_type              div_rsp;
   pdss_pkg::mul_req_type              mul_req;
   logic [pdss_pkg::PROD_W-1:0]        prod;

   logic [pdss_pkg::PARENT_W-1:0]      eff;
   logic [pdss_pkg::DIVD_W-1:0]        half;
   logic signed [26:0]                 num_s;
   logic [25:0]                        num_u;
   logic [12:0]                        pshift;
   logic [pdss_pkg::FRATE_W-1:0]       rate_full;
   logic [pdss_pkg::FRATE_W-1:0]       tgt_w;
   logic [pdss_pkg::FRATE_W-1:0]       delta;
   logic [pdss_pkg::RATE_W-1:0]        rate_sat;
   pdss_pkg::tab_hit_type              tab;
   logic                               last_cand;

   assign eff    = (parent_ff == '0) ? pdss_pkg::PARENT_W'(1) : parent_ff;
   assign half   = pdss_pkg::DIVD_W'(eff[pdss_pkg::PARENT_W-1:1]);
   assign num_s  = $signed({1'b0, m_ff, 16'b0}) + 27'(k_ff);
   assign num_u  = num_s[26] ? 26'd0 : num_s[25:0];
   assign pshift = 13'(p_ff) << s_ff;
   assign rate_full = div_rsp.quotient[pdss_pkg::FRATE_W-1:0];
   assign tgt_w  = pdss_pkg::FRATE_W'(req_ff.target_rate);
   assign delta  = (rate_full > tgt_w) ? rate_full - tgt_w : tgt_w - rate_full;
   assign rate_sat = (|rate_full[pdss_pkg::FRATE_W-1:pdss_pkg::RATE_W]) ?
                     '1 : rate_full[pdss_pkg::RATE_W-1:0];
   assign tab    = pdss_pkg::tab_lookup(req_ff.pll_kind, req_ff.target_rate);
   assign last_cand = (p_ff == pdss_pkg::PDIV_LIMIT) && (s_ff == pdss_pkg::SDIV_LIMIT);

   // operand selection for the shared units
   always_comb begin
      mul_req = '0;
      case (state_ff)
         ST_RMUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = pdss_pkg::MUL_A_W'(num_u);
            mul_req.b  = eff;
         end
         ST_QMUL: begin
            mul_req.en = 1'b1;
            mul_req.a  = req_ff.target_rate;
            mul_req.b  = pdss_pkg::MUL_B_W'(pshift);
         end
         default: mul_req = '0;
      endcase
   end

   always_comb begin
      div_req       = '0;
      div_req.start = 1'b0;
      case (state_ff)
         ST_RDIV: begin
            div_req.start    = !div_run_ff;
            div_req.dividend = pdss_pkg::DIVD_W'(prod >> (6'd16 + 6'(s_ff)));
            div_req.divisor  = pdss_pkg::DIVS_W'(p_ff);
         end
         ST_MDIV: begin
            div_req.start    = !div_run_ff;
            div_req.dividend = pdss_pkg::DIVD_W'(prod) + half;
            div_req.divisor  = eff;
         end
         ST_QDIV: begin
            div_req.start    = !div_run_ff;
            div_req.dividend = pdss_pkg::DIVD_W'({prod, 16'b0}) + half;
            div_req.divisor  = eff;
         end
         default: div_req = '0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      ph_in      = ph_ff;
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      parent_in  = parent_ff;
      m_in       = m_ff;
      p_in       = p_ff;
      s_in       = s_ff;
      k_in       = k_ff;
      lo_in      = lo_ff;
      best_in    = best_ff;
      have_in    = have_ff;
      div_run_in = div_run_ff;

      if (csr_write)
         parent_in = csr_wdata;
      if (div_req.start)
         div_run_in = 1'b1;
      if (div_rsp.done)
         div_run_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_TAB;
            end
         end
         ST_TAB: begin
            if (tab.hit) begin
               rsp_in.out_rate   = tab.entry.rate;
               rsp_in.out_mdiv   = tab.entry.m;
               rsp_in.out_pdiv   = tab.entry.p;
               rsp_in.out_sdiv   = tab.entry.s;
               rsp_in.out_kdiv   = tab.entry.k;
               rsp_in.path_taken = pdss_pkg::PATH_TABLE;
               state_in          = ST_OUT;
            end else if (req_ff.cur_pdiv != '0) begin
               m_in     = req_ff.cur_mdiv;
               p_in     = req_ff.cur_pdiv;
               s_in     = req_ff.cur_sdiv;
               k_in     = pdss_pkg::K_MIN;
               ph_in    = PH_LO;
               state_in = ST_RMUL;
            end else begin
               p_in     = 6'd1;
               s_in     = 3'd0;
               have_in  = 1'b0;
               ph_in    = PH_SRCH;
               state_in = ST_QMUL;
            end
         end
         ST_RMUL: state_in = ST_RDIV;
         ST_RDIV: begin
            if (div_rsp.done) begin
               case (ph_ff)
                  PH_LO: begin
                     lo_in    = rate_full;
                     k_in     = pdss_pkg::K_MAX;
                     ph_in    = PH_HI;
                     state_in = ST_RMUL;
                  end
                  PH_HI: begin
                     state_in = ST_QMUL;
                     if (tgt_w >= lo_ff && tgt_w <= rate_full) begin
                        ph_in = PH_KFIN;
                     end else begin
                        p_in    = 6'd1;
                        s_in    = 3'd0;
                        have_in = 1'b0;
                        ph_in   = PH_SRCH;
                     end
                  end
                  PH_KFIN: begin
                     rsp_in.out_rate   = rate_sat;
                     rsp_in.out_mdiv   = m_ff;
                     rsp_in.out_pdiv   = p_ff;
                     rsp_in.out_sdiv   = s_ff;
                     rsp_in.out_kdiv   = k_ff;
                     rsp_in.path_taken = pdss_pkg::PATH_KADJ;
                     state_in          = ST_OUT;
                  end
                  default: begin
                     // search candidate: keep the first closest one
                     state_in = ST_QMUL;
                     if (!have_ff || delta < best_ff) begin
                        have_in           = 1'b1;
                        best_in           = delta;
                        rsp_in.out_rate   = rate_sat;
                        rsp_in.out_mdiv   = m_ff;
                        rsp_in.out_pdiv   = p_ff;
                        rsp_in.out_sdiv   = s_ff;
                        rsp_in.out_kdiv   = k_ff;
                        rsp_in.path_taken = pdss_pkg::PATH_SEARCH;
                        if (delta == '0)
                           state_in = ST_OUT;
                     end
                     if (last_cand)
                        state_in = ST_OUT;
                     if (s_ff == pdss_pkg::SDIV_LIMIT) begin
                        s_in = 3'd0;
                        p_in = p_ff + 6'd1;
                     end else begin
                        s_in = s_ff + 3'd1;
                     end
                  end
               endcase
            end
         end
         ST_QMUL: state_in = (ph_ff == PH_SRCH) ? ST_MDIV : ST_QDIV;
         ST_MDIV: begin
            if (div_rsp.done) begin
               m_in     = pdss_pkg::clamp_m(div_rsp.quotient);
               state_in = ST_QDIV;
            end
         end
         ST_QDIV: begin
            if (div_rsp.done) begin
               k_in     = pdss_pkg::k_sat(div_rsp.quotient, m_ff);
               state_in = ST_RMUL;
            end
         end
         ST_OUT: begin
            if (!rsp_stall)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ph_ff      <= PH_LO;
         parent_ff  <= pdss_pkg::PARENT_RESET;
         have_ff    <= 1'b0;
         div_run_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ph_ff      <= ph_in;
         parent_ff  <= parent_in;
         have_ff    <= have_in;
         div_run_ff <= div_run_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      m_ff    <= m_in;
      p_ff    <= p_in;
      s_ff    <= s_in;
      k_ff    <= k_in;
      lo_ff   <= lo_in;
      best_ff <= best_in;
   end

   pdss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pdss_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/pdss_checker.sv -----
// ----------------------------------------------------------------------------
// pdss_checker
// Port-level checks on the PLL divider search unit.
// ----------------------------------------------------------------------------
module pdss_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input pdss_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pdss_pkg::rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an accepted request never answers in the next cycle
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response in cycle after request");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   // search results keep m inside its clamp range
   a_search_m: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.path_taken == pdss_pkg::PATH_SEARCH
         |-> rsp_data.out_mdiv >= pdss_pkg::M_MIN && rsp_data.out_pdiv != 6'd0)
      else $error("search result out of range");

endmodule

bind pll_divider_settings_search_unit pdss_checker u_pdss_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// PLL divider search unit testbench
// Sends divider requests through the table, k-only and full search paths
// under several parent rates. Every response is checked against an in-bench
// model of the divider choice, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES   = 20;
   localparam logic [63:0] RATE_CEIL = 64'hFFFF_FFFF;

   logic     clock = 1'b0;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   pdss_pkg::req_type  req_data;
   logic     rsp_valid;
   logic     rsp_stall;
   pdss_pkg::rsp_type  rsp_data;
   logic     csr_write;
   logic [pdss_pkg::PARENT_W-1:0] csr_wdata;

   pll_divider_settings_search_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   // divider table, own copy
   pdss_pkg::tab_entry_type int_rates [14] = '{
      '{32'd1800000000, 10'd225, 6'd3, 3'd0, 16'sd0},
      '{32'd1600000000, 10'd200, 6'd3, 3'd0, 16'sd0},
      '{32'd1500000000, 10'd375, 6'd3, 3'd1, 16'sd0},
      '{32'd1400000000, 10'd350, 6'd3, 3'd1, 16'sd0},
      '{32'd1200000000, 10'd300, 6'd3, 3'd1, 16'sd0},
      '{32'd1000000000, 10'd250, 6'd3, 3'd1, 16'sd0},
      '{32'd800000000,  10'd200, 6'd3, 3'd1, 16'sd0},
      '{32'd750000000,  10'd250, 6'd2, 3'd2, 16'sd0},
      '{32'd700000000,  10'd350, 6'd3, 3'd2, 16'sd0},
      '{32'd640000000,  10'd320, 6'd3, 3'd2, 16'sd0},
      '{32'd600000000,  10'd300, 6'd3, 3'd2, 16'sd0},
      '{32'd416000000,  10'd208, 6'd3, 3'd2, 16'sd0},
      '{32'd320000000,  10'd160, 6'd3, 3'd2, 16'sd0},
      '{32'd208000000,  10'd208, 6'd3, 3'd3, 16'sd0}
   };
   pdss_pkg::tab_entry_type frac_rates [4] = '{
      '{32'd1039500000, 10'd173, 6'd2, 3'd1, 16'sd16384},
      '{32'd650000000,  10'd325, 6'd3, 3'd2, 16'sd0},
      '{32'd594000000,  10'd198, 6'd2, 3'd2, 16'sd0},
      '{32'd519750000,  10'd173, 6'd2, 3'd2, 16'sd16384}
   };

   logic [pdss_pkg::PARENT_W-1:0] parent_hz;
   pdss_pkg::rsp_type divider_expect_q [$];
   int mismatches = 0;
   int burst_left;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] eff_parent(input logic [pdss_pkg::PARENT_W-1:0] pr);
      return (pr == '0) ? 64'd1 : 64'(pr);
   endfunction

   function automatic logic [63:0] pll_rate(input logic [63:0] par, input logic [63:0] m,
                                            input logic [63:0] p, input logic [63:0] s,
                                            input int k);
      longint num;
      num = longint'(m * 64'd65536) + longint'(k);
      if (num < 0) return 64'd0;
      return (par * 64'(num)) / ((p * 64'd65536) << s);
   endfunction

   function automatic int frac_k(input logic [63:0] par, input logic [63:0] m,
                                 input logic [63:0] p, input logic [63:0] s,
                                 input logic [63:0] tgt);
      logic [63:0] q;
      logic [63:0] base;
      logic [63:0] d;
      q    = (tgt * ((p * 64'd65536) << s) + par / 2) / par;
      base = m * 64'd65536;
      if (q >= base) begin
         d = q - base;
         return (d > 64'd32767) ? 32767 : int'(d);
      end
      d = base - q;
      return (d > 64'd32768) ? -32768 : -int'(d);
   endfunction

   function automatic pdss_pkg::rsp_type make_rsp(input logic [63:0] rate,
                                                  input logic [63:0] m,
                                                  input logic [63:0] p,
                                                  input logic [63:0] s,
                                                  input int k, input logic [1:0] path);
      pdss_pkg::rsp_type r;
      r.out_rate   = (rate > RATE_CEIL) ? 32'hFFFF_FFFF : rate[31:0];
      r.out_mdiv   = m[9:0];
      r.out_pdiv   = p[5:0];
      r.out_sdiv   = s[2:0];
      r.out_kdiv   = 16'(k);
      r.path_taken = path;
      return r;
   endfunction

   function automatic pdss_pkg::rsp_type predict_dividers(
         input pdss_pkg::req_type rq, input logic [pdss_pkg::PARENT_W-1:0] pr);
      logic [63:0] par;
      logic [63:0] tgt;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] cm;
      logic [63:0] cp;
      logic [63:0] cs;
      logic [63:0] m;
      logic [63:0] r;
      logic [63:0] delta;
      logic [63:0] best;
      int k;
      pdss_pkg::rsp_type res;
      par = eff_parent(pr);
      tgt = 64'(rq.target_rate);
      cm  = 64'(rq.cur_mdiv);
      cp  = 64'(rq.cur_pdiv);
      cs  = 64'(rq.cur_sdiv);
      if (rq.pll_kind == pdss_pkg::KIND_INT) begin
         foreach (int_rates[i])
            if (rq.target_rate == int_rates[i].rate)
               return make_rsp(64'(int_rates[i].rate), 64'(int_rates[i].m),
                               64'(int_rates[i].p), 64'(int_rates[i].s),
                               int'(int_rates[i].k), pdss_pkg::PATH_TABLE);
      end else begin
         foreach (frac_rates[i])
            if (rq.target_rate == frac_rates[i].rate)
               return make_rsp(64'(frac_rates[i].rate), 64'(frac_rates[i].m),
                               64'(frac_rates[i].p), 64'(frac_rates[i].s),
                               int'(frac_rates[i].k), pdss_pkg::PATH_TABLE);
      end
      if (rq.cur_pdiv != 0) begin
         lo = pll_rate(par, cm, cp, cs, -32768);
         hi = pll_rate(par, cm, cp, cs, 32767);
         if (tgt >= lo && tgt <= hi) begin
            k = frac_k(par, cm, cp, cs, tgt);
            return make_rsp(pll_rate(par, cm, cp, cs, k), cm, cp, cs, k,
                            pdss_pkg::PATH_KADJ);
         end
      end
      best = '1;
      res  = make_rsp(64'd0, 64'd0, 64'd0, 64'd0, 0, pdss_pkg::PATH_SEARCH);
      for (int p = 1; p <= 63; p++) begin
         for (int s = 0; s <= 6; s++) begin
            m = (tgt * (64'(p) << s) + par / 2) / par;
            if (m < 64) m = 64;
            if (m > 1023) m = 1023;
            k = frac_k(par, m, 64'(p), 64'(s), tgt);
            r = pll_rate(par, m, 64'(p), 64'(s), k);
            delta = (r > tgt) ? r - tgt : tgt - r;
            if (p == 1 && s == 0 || delta < best) begin
               best = delta;
               res  = make_rsp(r, m, 64'(p), 64'(s), k, pdss_pkg::PATH_SEARCH);
               if (delta == 0) return res;
            end
         end
      end
      return res;
   endfunction

   // response checker, receiver stall pattern and watchdog
   always @(posedge clock) begin
      pdss_pkg::rsp_type want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (divider_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response %p", rsp_data);
            end else begin
               want = divider_expect_q.pop_front();
               if (rsp_data.out_rate !== want.out_rate || rsp_data.out_mdiv !== want.out_mdiv
                   || rsp_data.out_pdiv !== want.out_pdiv
                   || rsp_data.out_sdiv !== want.out_sdiv
                   || rsp_data.out_kdiv !== want.out_kdiv
                   || rsp_data.path_taken !== want.path_taken) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if (stall_phase == 0) begin
            stall_mode  = $urandom_range(0, 2);
            stall_phase = $urandom_range(8, 64);
         end
         stall_phase--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= (stall_phase % 4 != 0);
         endcase
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [31:0] tgt,
                               input logic [9:0] cm, input logic [5:0] cp,
                               input logic [2:0] cs);
      int gap;
      pdss_pkg::req_type rq;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      rq = '{pll_kind: kind, target_rate: tgt, cur_mdiv: cm, cur_pdiv: cp, cur_sdiv: cs};
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      divider_expect_q.push_back(predict_dividers(rq, parent_hz));
   endtask

   // wait for all responses, then let the unit settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (divider_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_parent(input logic [pdss_pkg::PARENT_W-1:0] value);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= value;
      parent_hz = value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_table_hit();
      int kind;
      int idx;
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
         idx = $urandom_range(0, 13);
         send_request(2'(kind), int_rates[idx].rate, 10'($urandom), 6'($urandom),
                      3'($urandom));
      end else begin
         idx = $urandom_range(0, 3);
         send_request(2'(kind), frac_rates[idx].rate, 10'($urandom), 6'($urandom),
                      3'($urandom));
      end
   endtask

   task automatic send_kadj();
      logic [63:0] par;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [9:0] cm;
      logic [5:0] cp;
      logic [2:0] cs;
      par = eff_parent(parent_hz);
      do begin
         cm = 10'($urandom);
         cp = 6'($urandom_range(1, 63));
         cs = 3'($urandom);
         lo = pll_rate(par, 64'(cm), 64'(cp), 64'(cs), -32768);
         hi = pll_rate(par, 64'(cm), 64'(cp), 64'(cs), 32767);
         if (hi > RATE_CEIL) hi = RATE_CEIL;
      end while (lo > hi);
      send_request(2'($urandom), 32'(lo + {$urandom, $urandom} % (hi - lo + 1)), cm, cp, cs);
   endtask

   // first candidate (p 1, s 0, k 0) is an exact hit
   task automatic send_quick_search();
      logic [63:0] par;
      logic [63:0] mtop;
      par  = eff_parent(parent_hz);
      mtop = RATE_CEIL / par;
      if (mtop > 1023) mtop = 1023;
      if (mtop < 64) begin
         send_table_hit();
         return;
      end
      send_request(2'($urandom), 32'(par * 64'($urandom_range(64, int'(mtop)))),
                   10'($urandom), 6'd0, 3'($urandom));
   endtask

   task automatic test_table();
      foreach (int_rates[i])
         send_request(pdss_pkg::KIND_INT, int_rates[i].rate, 10'd0, 6'd1, 3'd0);
      foreach (frac_rates[i]) send_request(2'(1 + i % 3), frac_rates[i].rate, 10'd1023,
                                           6'd63, 3'd7);
      send_request(2'd3, 32'd1039500000, 10'd5, 6'd0, 3'd0);
      send_request(pdss_pkg::KIND_INT, 32'd650000000, 10'd325, 6'd3, 3'd2);
   endtask

   task automatic test_kadj();
      send_request(2'd1, 32'd600123456, 10'd300, 6'd3, 3'd2);
      // m of zero: negative numerator gives rate 0
      send_request(2'd1, 32'd0, 10'd0, 6'd1, 3'd0);
      send_request(2'd2, 32'd1, 10'd0, 6'd63, 3'd7);
   endtask

   task automatic test_search();
      send_request(pdss_pkg::KIND_INT, 32'd2400000000, 10'd0, 6'd0, 3'd0);
      send_request(2'd1, 32'd0, 10'd100, 6'd0, 3'd0);
      send_request(pdss_pkg::KIND_INT, 32'd1234567891, 10'd1, 6'd1, 3'd0);
      drain();
   endtask

   task automatic test_parent_extremes();
      set_parent(27'd100000000);
      send_request(pdss_pkg::KIND_INT, 32'hFFFF_FFFF, 10'd1023, 6'd1, 3'd0);
      send_request(2'd1, 32'd1039500000, 10'd0, 6'd1, 3'd0);
      set_parent(27'h7FF_FFFF);
      send_request(2'd1, 32'hFFFF_FFFF, 10'd1023, 6'd1, 3'd0);
      set_parent(27'd0);
      send_request(pdss_pkg::KIND_INT, 32'd500, 10'd500, 6'd1, 3'd0);
      send_request(2'd2, 32'd700, 10'd0, 6'd0, 3'd0);
      set_parent(27'd1);
      send_request(pdss_pkg::KIND_INT, 32'd300, 10'd0, 6'd0, 3'd0);
   endtask

   task automatic test_random();
      logic [pdss_pkg::PARENT_W-1:0] parents [5];
      int pick;
      parents = '{27'd24000000, 27'd1, 27'd100000000, 27'd25000000, 27'($urandom)};
      foreach (parents[ph]) begin
         set_parent(parents[ph]);
         for (int n = 0; n < 16; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) send_table_hit();
            else if (pick < 85) send_kadj();
            else if (pick < 97) send_quick_search();
            else send_request(2'($urandom), $urandom, 10'($urandom), 6'($urandom),
                              3'($urandom));
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_write   = 1'b0;
      csr_wdata   = '0;
      parent_hz   = pdss_pkg::PARENT_RESET;
      burst_left  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table();
      test_kadj();
      test_search();
      test_parent_extremes();
      test_random();
      drain();
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
